### rtl/plc_pkg.sv
// Shared constants, codes and control structs of the positional list engine.
`timescale 1ns / 1ps

package plc_pkg;

    // Default sizing, handed down from the top level
    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int ITEM_W   = 32;
    localparam int LEN_W    = 6;

    localparam int S_TDATA_W = 40;   // value, position, padding
    localparam int M_TDATA_W = 48;   // item, item_position, length, padding

    // Command codes
    localparam logic [MODE_W-1:0] MODE_INS_FIRST = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_LAST  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_AT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FIRST = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_LAST  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_AT    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DUMP      = 3'd6;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic exec;       // run the accepted request
        logic dump_step;  // emit the head element and rotate the row
    } plc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic empty;      // list holds no element
        logic dump_last;  // current dump element is the last one
    } plc_stat_t;

endpackage

### rtl/plc_ctrl.sv
// Controller state machine of the positional list engine.
`timescale 1ns / 1ps

module plc_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [plc_pkg::MODE_W-1:0]   mode,
    input  plc_pkg::plc_stat_t           stat,
    output plc_pkg::plc_cmd_t            cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        cmd.exec      = 1'b0;
        cmd.dump_step = 1'b0;
        case (state_reg)
            S_IDLE: begin
                cmd.exec = accept;
                if (accept && (mode == plc_pkg::MODE_DUMP) && !stat.empty) begin
                    state_next = S_DUMP;
                end
            end
            S_DUMP: begin
                cmd.dump_step = stat.out_free;
                if (stat.out_free && stat.dump_last) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/plc_datapath.sv
// Shifting cell row, element count and result register of the positional list engine.
`timescale 1ns / 1ps

module plc_datapath #(
    parameter int CAPACITY   = plc_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = plc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  plc_pkg::plc_cmd_t                   cmd,
    output plc_pkg::plc_stat_t                  stat,
    input  logic [plc_pkg::MODE_W-1:0]          mode,
    input  logic signed [plc_pkg::VALUE_W-1:0]  value,
    input  logic [plc_pkg::POS_W-1:0]           position,
    input  logic                                m_tready,
    output logic                                m_valid,
    output logic [plc_pkg::STATUS_W-1:0]        out_status,
    output logic signed [plc_pkg::ITEM_W-1:0]   out_item,
    output logic [plc_pkg::POS_W-1:0]           out_item_position,
    output logic [plc_pkg::LEN_W-1:0]           out_length,
    output logic                                out_final
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = ((CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W) + 1;
    localparam int STATUS_W_FIX = plc_pkg::STATUS_W;

    logic signed [DATA_WIDTH-1:0] cells_reg [CAPACITY];
    logic signed [DATA_WIDTH-1:0] up_w      [CAPACITY];
    logic signed [DATA_WIDTH-1:0] dn_w      [CAPACITY];
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] dump_idx_reg;
    logic          m_valid_reg;

    logic [STATUS_W_FIX-1:0] status_reg;
    logic signed [plc_pkg::ITEM_W-1:0] item_reg;
    logic [plc_pkg::POS_W-1:0] item_pos_reg;
    logic [plc_pkg::LEN_W-1:0] length_reg;
    logic                      final_reg;

    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] pos_m1;
    logic [PW-1:0] new_cnt;
    logic [PW-1:0] dump_pos;
    logic          full;
    logic          empty;
    logic          ins_en;
    logic          del_en;
    logic [IW-1:0] ins_idx;
    logic [IW-1:0] del_idx;
    logic [STATUS_W_FIX-1:0] res_status;
    logic          res_load;
    logic signed [DATA_WIDTH-1:0] word;

    // Neighbour taps of each cell
    for (genvar g = 0; g < CAPACITY; g++) begin : g_taps
        if (g == CAPACITY - 1) begin : g_top
            assign up_w[g] = cells_reg[g];
        end else begin : g_mid
            assign up_w[g] = cells_reg[g+1];
        end
        if (g == 0) begin : g_bot
            assign dn_w[g] = cells_reg[g];
        end else begin : g_low
            assign dn_w[g] = cells_reg[g-1];
        end
    end

    assign cnt_ext  = PW'(cnt_reg);
    assign pos_ext  = PW'(position);
    assign pos_m1   = pos_ext - PW'(1);
    assign full     = (cnt_ext == PW'(CAPACITY));
    assign empty    = (cnt_reg == '0);
    assign dump_pos = PW'(dump_idx_reg) + PW'(1);
    assign word     = DATA_WIDTH'(value);

    always_comb begin
        ins_en     = 1'b0;
        del_en     = 1'b0;
        ins_idx    = '0;
        del_idx    = '0;
        res_status = plc_pkg::ST_OK;
        res_load   = 1'b1;
        case (mode)
            plc_pkg::MODE_INS_FIRST, plc_pkg::MODE_INS_LAST, plc_pkg::MODE_INS_AT: begin
                if (full) begin
                    res_status = plc_pkg::ST_FULL;
                end else if (mode == plc_pkg::MODE_INS_FIRST) begin
                    ins_en = 1'b1;
                end else if (mode == plc_pkg::MODE_INS_LAST) begin
                    ins_en  = 1'b1;
                    ins_idx = IW'(cnt_reg);
                end else if ((pos_ext == '0) || (pos_ext > cnt_ext + PW'(1))) begin
                    res_status = plc_pkg::ST_BADPOS;
                end else begin
                    ins_en  = 1'b1;
                    ins_idx = IW'(pos_m1);
                end
            end
            plc_pkg::MODE_DEL_FIRST, plc_pkg::MODE_DEL_LAST, plc_pkg::MODE_DEL_AT: begin
                if (empty) begin
                    res_status = plc_pkg::ST_EMPTY;
                end else if (mode == plc_pkg::MODE_DEL_FIRST) begin
                    del_en = 1'b1;
                end else if (mode == plc_pkg::MODE_DEL_LAST) begin
                    del_en  = 1'b1;
                    del_idx = IW'(cnt_ext - PW'(1));
                end else if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                    res_status = plc_pkg::ST_BADPOS;
                end else begin
                    del_en  = 1'b1;
                    del_idx = IW'(pos_m1);
                end
            end
            plc_pkg::MODE_DUMP: begin
                // a non-empty dump answers through the dump steps
                if (empty) begin
                    res_status = plc_pkg::ST_EMPTY;
                end else begin
                    res_load = 1'b0;
                end
            end
            default: begin
                res_status = plc_pkg::ST_OK;
            end
        endcase
    end

    assign new_cnt = ins_en ? (cnt_ext + PW'(1)) :
                     del_en ? (cnt_ext - PW'(1)) : cnt_ext;

    // Cell row: shift up on insert, down on delete, rotate on dump
    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (cmd.exec && ins_en) begin
                if (PW'(i) == PW'(ins_idx)) begin
                    cells_reg[i] <= word;
                end else if ((PW'(i) > PW'(ins_idx)) && (PW'(i) <= cnt_ext)) begin
                    cells_reg[i] <= dn_w[i];
                end
            end else if (cmd.exec && del_en) begin
                if ((PW'(i) >= PW'(del_idx)) && (PW'(i) + PW'(1) < cnt_ext)) begin
                    cells_reg[i] <= up_w[i];
                end
            end else if (cmd.dump_step) begin
                if (PW'(i) + PW'(1) == cnt_ext) begin
                    cells_reg[i] <= cells_reg[0];
                end else if (PW'(i) + PW'(1) < cnt_ext) begin
                    cells_reg[i] <= up_w[i];
                end
            end
        end
    end

    // Count, dump index and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            dump_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.exec) begin
                cnt_reg      <= CW'(new_cnt);
                dump_idx_reg <= '0;
            end else if (cmd.dump_step) begin
                dump_idx_reg <= dump_idx_reg + IW'(1);
            end
            if ((cmd.exec && res_load) || cmd.dump_step) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.exec && res_load) begin
            status_reg   <= res_status;
            item_reg     <= '0;
            item_pos_reg <= '0;
            length_reg   <= new_cnt[plc_pkg::LEN_W-1:0];
            final_reg    <= 1'b1;
        end else if (cmd.dump_step) begin
            status_reg   <= plc_pkg::ST_OK;
            item_reg     <= plc_pkg::ITEM_W'(cells_reg[0]);
            item_pos_reg <= dump_pos[plc_pkg::POS_W-1:0];
            length_reg   <= cnt_ext[plc_pkg::LEN_W-1:0];
            final_reg    <= stat.dump_last;
        end
    end

    assign stat.out_free  = !m_valid_reg || m_tready;
    assign stat.empty     = empty;
    assign stat.dump_last = (dump_pos == cnt_ext);

    assign m_valid           = m_valid_reg;
    assign out_status        = status_reg;
    assign out_item          = item_reg;
    assign out_item_position = item_pos_reg;
    assign out_length        = length_reg;
    assign out_final         = final_reg;

endmodule

### rtl/positional_list_engine.sv
// Top level of the positional list engine: controller, datapath and stream ports.
// Results are registered; the first element of a dump follows the controller's move to its dump state.
// An insert or delete shifts the cell row as it is taken; a dump holds the input
// until its last element is out, with one rotation of the row per element.
// Output stalls hold the block; a new request is taken as the pending result leaves.
// Reset (aresetn low, synchronous) empties the list; stored words are left as they are.
`timescale 1ns / 1ps

module positional_list_engine #(
    parameter int CAPACITY   = plc_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = plc_pkg::DATA_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [plc_pkg::S_TDATA_W-1:0]     s_tdata,  // value[31:0], position[37:32], zero pad
    input  logic [plc_pkg::MODE_W-1:0]        s_tuser,  // mode[2:0]
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [plc_pkg::M_TDATA_W-1:0]     m_tdata,  // item[31:0], item_position[37:32],
                                                        // length[43:38], zero pad
    output logic [plc_pkg::STATUS_W-1:0]      m_tuser,  // status[1:0]
    output logic                              m_tlast   // final_res
);

    plc_pkg::plc_cmd_t  cmd;
    plc_pkg::plc_stat_t stat;

    logic signed [plc_pkg::VALUE_W-1:0] value;
    logic [plc_pkg::POS_W-1:0]          position;
    logic signed [plc_pkg::ITEM_W-1:0]  item;
    logic [plc_pkg::POS_W-1:0]          item_position;
    logic [plc_pkg::LEN_W-1:0]          length;

    // Unpack the request
    assign value    = $signed(s_tdata[31:0]);
    assign position = s_tdata[37:32];

    // Sequence requests and dump steps
    plc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the list and build each result
    plc_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .mode              (s_tuser),
        .value             (value),
        .position          (position),
        .m_tready          (m_tready),
        .m_valid           (m_tvalid),
        .out_status        (m_tuser),
        .out_item          (item),
        .out_item_position (item_position),
        .out_length        (length),
        .out_final         (m_tlast)
    );

    // Pack the result
    assign m_tdata = {4'd0, length, item_position, item};

`ifndef SYNTHESIS
    // a request is only taken when the output register can receive its result
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("request taken while output register busy");

    // a dump in progress blocks new requests
    a_dump_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("request taken during a dump");

    // a taken non-final dump result is followed at once by the next one
    a_dump_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("dump result missing after a non-final one");

    // full status only reports a full list
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == plc_pkg::ST_FULL)) |->
            (length == plc_pkg::LEN_W'(CAPACITY)))
        else $error("full status with short list");
`endif

endmodule
